FILE: rtl/tdh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdh_pkg
// Shared constants, types and helpers of the timer deadline heap.
// ----------------------------------------------------------------------------
package tdh_pkg;

    localparam int CAPACITY    = 32;
    localparam int MAX_RESULTS = 32;
    localparam int IW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW          = $clog2(CAPACITY + 1);
    localparam int LW          = IW + 2;
    localparam int NW          = $clog2(MAX_RESULTS + 1);
    localparam int TW          = 48;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;

    localparam logic [TW-1:0] TIME_MAX = '1;

    // Field order gives deadline-then-id ordering as one unsigned compare.
    typedef struct packed {
        logic [TW-1:0] dl;
        logic [31:0]   id;
    } t_key;

    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                              input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? TIME_MAX : s[TW-1:0];
    endfunction

    // Clamp current time minus deadline into 17-bit signed.
    function automatic logic [16:0] late_calc(input logic [TW-1:0] now,
                                              input logic [TW-1:0] dl);
        logic [TW-1:0] d;
        logic [16:0]   r;
        if (now >= dl) begin
            d = now - dl;
            r = (d > TW'(65535)) ? 17'd65535 : {1'b0, d[15:0]};
        end else begin
            d = dl - now;
            r = (d > TW'(65536)) ? 17'h10000 : (17'd0 - d[16:0]);
        end
        return r;
    endfunction

endpackage

FILE: rtl/timer_deadline_heap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_deadline_heap
// Timer scheduler over a deadline-ordered min-heap with add, cancel and tick.
//
// channel   dir  fields
// s_axis    in   tuser: cmd[1:0]; tdata: interval[31:0], timer_id[63:32]
// m_axis    out  tuser: kind[1:0]; tdata: result_id, ok, lateness; tlast: last
// cfg       in   i_cfg_we / i_cfg_wdata: tolerance[15:0]
//
// One command at a time; s_axis_tready is high only when idle.
// Add sifts the new entry up the heap one level at a time. Cancel scans the entries
// in order and then does one sift. Tick works out the limit, then fires the due entries
// one at a time, each with a sift; all set by the single read port of the heap store and the one comparator.
// A result waits in the output register until taken; the sequencer holds.
// Reset clears time, id counter, entry count; tolerance returns to 1.
// ----------------------------------------------------------------------------
module timer_deadline_heap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // interval[31:0], timer_id[63:32]
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // result_id[31:0], ok[32], lateness[49:33]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    localparam int IW = tdh_pkg::IW;
    localparam int CW = tdh_pkg::CW;
    localparam int LW = tdh_pkg::LW;
    localparam int NW = tdh_pkg::NW;
    localparam int TW = tdh_pkg::TW;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_RD   = 4'd1;
    localparam logic [3:0] S_UP_CMP  = 4'd2;
    localparam logic [3:0] S_DN_L    = 4'd3;
    localparam logic [3:0] S_DN_LC   = 4'd4;
    localparam logic [3:0] S_DN_RC   = 4'd5;
    localparam logic [3:0] S_DN_DEC  = 4'd6;
    localparam logic [3:0] S_WR_FIN  = 4'd7;
    localparam logic [3:0] S_SC_RD   = 4'd8;
    localparam logic [3:0] S_SC_CHK  = 4'd9;
    localparam logic [3:0] S_RM_X    = 4'd10;
    localparam logic [3:0] S_TK_LIM  = 4'd11;
    localparam logic [3:0] S_TK_RD   = 4'd12;
    localparam logic [3:0] S_TK_CHK  = 4'd13;
    localparam logic [3:0] S_TK_FIRE = 4'd14;
    localparam logic [3:0] S_OUT     = 4'd15;

    logic [3:0]    r_state, n_state;
    logic [3:0]    r_ret, n_ret;
    logic [1:0]    r_op, n_op;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [31:0]   r_nid, n_nid;
    logic [TW-1:0] r_now, n_now;
    logic [TW-1:0] r_limit, n_limit;
    logic [15:0]   r_tol;
    logic [IW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_bidx, n_bidx;
    logic          r_moved, n_moved;
    logic          r_down, n_down;
    logic [NW-1:0] r_nfire, n_nfire;
    logic          r_pend, n_pend;
    logic [31:0]   r_tid, n_tid;
    logic [31:0]   r_pid, n_pid;
    logic [16:0]   r_plate, n_plate;
    tdh_pkg::t_key r_x, n_x;
    tdh_pkg::t_key r_best, n_best;
    tdh_pkg::t_key r_root, n_root;
    logic [1:0]    r_okind, n_okind;
    logic [31:0]   r_oid, n_oid;
    logic          r_ook, n_ook;
    logic [16:0]   r_olate, n_olate;
    logic          r_olast, n_olast;

    logic          we, re, lt;
    logic [IW-1:0] waddr, raddr;
    tdh_pkg::t_key wdata, rdata, cmp_a, cmp_b;
    logic [LW-1:0] lidx, ridx, cnt_x;
    logic [IW-1:0] pidx;
    logic [CW-1:0] cnt_dec;
    logic          due;

    tdh_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tdh_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_lt (lt)
    );

    assign lidx    = {1'b0, r_idx, 1'b1};
    assign ridx    = lidx + LW'(1);
    assign cnt_x   = LW'(r_cnt);
    assign pidx    = IW'((r_idx - IW'(1)) >> 1);
    assign cnt_dec = r_cnt - CW'(1);
    assign due     = (r_nfire < NW'(tdh_pkg::MAX_RESULTS)) && !lt;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {6'd0, r_olate, r_ook, r_oid};
    assign m_axis_tuser  = r_okind;
    assign m_axis_tlast  = r_olast;

    always_comb begin
        cmp_a = r_x;
        cmp_b = rdata;
        case (r_state)
            S_DN_LC: begin
                cmp_a = rdata;
                cmp_b = r_x;
            end
            S_DN_RC: begin
                cmp_a = rdata;
                cmp_b = r_best;
            end
            S_TK_CHK: begin
                // deadline within limit when the limit key is not before it
                cmp_a = {r_limit, 32'hFFFF_FFFF};
                cmp_b = rdata;
            end
            default: begin
                cmp_a = r_x;
                cmp_b = rdata;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;  n_ret = r_ret;    n_op = r_op;
        n_cnt = r_cnt;      n_nid = r_nid;    n_now = r_now;
        n_limit = r_limit;  n_idx = r_idx;    n_bidx = r_bidx;
        n_moved = r_moved;  n_down = r_down;  n_nfire = r_nfire;
        n_pend = r_pend;    n_tid = r_tid;    n_pid = r_pid;
        n_plate = r_plate;  n_x = r_x;        n_best = r_best;
        n_root = r_root;    n_okind = r_okind; n_oid = r_oid;
        n_ook = r_ook;      n_olate = r_olate; n_olast = r_olast;
        we = 1'b0;  waddr = r_idx;  wdata = r_x;
        re = 1'b0;  raddr = r_idx;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op    = s_axis_tuser;
                    n_tid   = s_axis_tdata[63:32];
                    n_olate = '0;
                    n_olast = 1'b1;
                    n_ret   = S_IDLE;
                    case (s_axis_tuser)
                        tdh_pkg::CMD_ADD: begin
                            n_okind = tdh_pkg::KIND_ADD;
                            if (r_cnt >= CW'(tdh_pkg::CAPACITY)) begin
                                n_oid   = '0;
                                n_ook   = 1'b0;
                                n_state = S_OUT;
                            end else begin
                                n_oid   = r_nid;
                                n_ook   = 1'b1;
                                n_x     = {tdh_pkg::sat_add(r_now,
                                            TW'(s_axis_tdata[31:0])), r_nid};
                                n_idx   = IW'(r_cnt);
                                n_cnt   = r_cnt + CW'(1);
                                n_nid   = r_nid + 32'd1;
                                n_moved = 1'b0;
                                n_down  = 1'b0;
                                n_state = S_UP_RD;
                            end
                        end
                        tdh_pkg::CMD_CANCEL: begin
                            n_okind = tdh_pkg::KIND_CANCEL;
                            n_oid   = s_axis_tdata[63:32];
                            n_idx   = '0;
                            n_state = S_SC_RD;
                        end
                        tdh_pkg::CMD_TICK: begin
                            n_now   = tdh_pkg::sat_add(r_now, TW'(1));
                            n_nfire = '0;
                            n_pend  = 1'b0;
                            n_state = S_TK_LIM;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_TK_LIM: begin
                n_limit = tdh_pkg::sat_add(r_now, TW'(r_tol));
                n_state = S_TK_RD;
            end
            S_UP_RD: begin
                if (r_idx == '0) begin
                    n_state = (r_down && !r_moved) ? S_DN_L : S_WR_FIN;
                end else begin
                    re      = 1'b1;
                    raddr   = pidx;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (lt) begin
                    we      = 1'b1;
                    wdata   = rdata;
                    n_idx   = pidx;
                    n_moved = 1'b1;
                    n_state = S_UP_RD;
                end else begin
                    n_state = (r_down && !r_moved) ? S_DN_L : S_WR_FIN;
                end
            end
            S_DN_L: begin
                if (lidx >= cnt_x) begin
                    n_state = S_WR_FIN;
                end else begin
                    re      = 1'b1;
                    raddr   = IW'(lidx);
                    n_state = S_DN_LC;
                end
            end
            S_DN_LC: begin
                n_best = lt ? rdata : r_x;
                n_bidx = lt ? IW'(lidx) : r_idx;
                if (ridx < cnt_x) begin
                    re      = 1'b1;
                    raddr   = IW'(ridx);
                    n_state = S_DN_RC;
                end else begin
                    n_state = S_DN_DEC;
                end
            end
            S_DN_RC: begin
                if (lt) begin
                    n_best = rdata;
                    n_bidx = IW'(ridx);
                end
                n_state = S_DN_DEC;
            end
            S_DN_DEC: begin
                if (r_bidx == r_idx) begin
                    n_state = S_WR_FIN;
                end else begin
                    we      = 1'b1;
                    wdata   = r_best;
                    n_idx   = r_bidx;
                    n_state = S_DN_L;
                end
            end
            S_WR_FIN: begin
                we      = 1'b1;
                wdata   = r_x;
                n_state = (r_op == tdh_pkg::CMD_TICK) ? S_TK_RD : S_OUT;
            end
            S_SC_RD: begin
                if (CW'(r_idx) >= r_cnt) begin
                    n_ook   = 1'b0;
                    n_state = S_OUT;
                end else begin
                    re      = 1'b1;
                    raddr   = r_idx;
                    n_state = S_SC_CHK;
                end
            end
            S_SC_CHK: begin
                if (rdata.id == r_tid) begin
                    n_ook   = 1'b1;
                    n_cnt   = cnt_dec;
                    n_moved = 1'b0;
                    n_down  = 1'b1;
                    if (CW'(r_idx) == cnt_dec) begin
                        n_state = S_OUT;
                    end else begin
                        re      = 1'b1;
                        raddr   = IW'(cnt_dec);
                        n_state = S_RM_X;
                    end
                end else if (CW'(r_idx) + CW'(1) >= r_cnt) begin
                    // scan done without a match
                    n_ook   = 1'b0;
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + IW'(1);
                    n_state = S_SC_RD;
                end
            end
            S_RM_X: begin
                n_x     = rdata;
                n_state = S_UP_RD;
            end
            S_TK_RD: begin
                if (r_cnt == '0) begin
                    if (r_pend) begin
                        n_okind = tdh_pkg::KIND_EXPIRY;
                        n_oid   = r_pid;
                        n_ook   = 1'b1;
                        n_olate = r_plate;
                        n_olast = 1'b1;
                        n_pend  = 1'b0;
                        n_ret   = S_IDLE;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    re      = 1'b1;
                    raddr   = '0;
                    n_state = S_TK_CHK;
                end
            end
            S_TK_CHK: begin
                n_root = rdata;
                if (r_pend) begin
                    // emit the held expiry now that the next one is known
                    n_okind = tdh_pkg::KIND_EXPIRY;
                    n_oid   = r_pid;
                    n_ook   = 1'b1;
                    n_olate = r_plate;
                    n_olast = !due;
                    n_pend  = 1'b0;
                    n_ret   = due ? S_TK_FIRE : S_IDLE;
                    n_state = S_OUT;
                end else begin
                    n_state = due ? S_TK_FIRE : S_IDLE;
                end
            end
            S_TK_FIRE: begin
                n_pid   = r_root.id;
                n_plate = tdh_pkg::late_calc(r_now, r_root.dl);
                n_pend  = 1'b1;
                n_nfire = r_nfire + NW'(1);
                n_cnt   = cnt_dec;
                n_idx   = '0;
                n_moved = 1'b0;
                n_down  = 1'b1;
                if (cnt_dec == '0) begin
                    n_state = S_TK_RD;
                end else begin
                    re      = 1'b1;
                    raddr   = IW'(cnt_dec);
                    n_state = S_RM_X;
                end
            end
            S_OUT: begin
                if (m_axis_tready) begin
                    n_state = r_ret;
                    n_ret   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
            r_nid   <= '0;
            r_now   <= '0;
            r_tol   <= 16'd1;
            r_pend  <= 1'b0;
            r_nfire <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
            r_nid   <= n_nid;
            r_now   <= n_now;
            r_pend  <= n_pend;
            r_nfire <= n_nfire;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_limit <= n_limit;
        r_idx   <= n_idx;
        r_bidx  <= n_bidx;
        r_moved <= n_moved;
        r_down  <= n_down;
        r_tid   <= n_tid;
        r_pid   <= n_pid;
        r_plate <= n_plate;
        r_x     <= n_x;
        r_best  <= n_best;
        r_root  <= n_root;
        r_okind <= n_okind;
        r_oid   <= n_oid;
        r_ook   <= n_ook;
        r_olate <= n_olate;
        r_olast <= n_olast;
    end
endmodule

FILE: rtl/tdh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdh_ram
// Heap entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tdh_ram (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [tdh_pkg::IW-1:0] i_waddr,
    input  tdh_pkg::t_key       i_wdata,
    input  logic                i_re,
    input  logic [tdh_pkg::IW-1:0] i_raddr,
    output tdh_pkg::t_key       o_rdata
);
    tdh_pkg::t_key r_mem [tdh_pkg::CAPACITY];
    tdh_pkg::t_key r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/tdh_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdh_cmp
// Shared ordering unit: a before b by deadline, then by lower id.
// ----------------------------------------------------------------------------
module tdh_cmp (
    input  tdh_pkg::t_key i_a,
    input  tdh_pkg::t_key i_b,
    output logic          o_lt
);
    always_comb begin
        if (i_a.dl != i_b.dl) begin
            o_lt = i_a.dl < i_b.dl;
        end else begin
            o_lt = i_a.id < i_b.id;
        end
    end
endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the timer deadline heap. Add, cancel and tick
// commands go in over the input stream. A timer model in the bench works out
// the replies and expiries for each transfer. Each result on the output
// stream is compared with the oldest pending expectation. Both sides idle
// at random, and the tolerance register is swept between phases.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         WATCH_MAX  = 5000;
    localparam int         TW         = tdh_pkg::TW;
    localparam int         CAP        = tdh_pkg::CAPACITY;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] id;
        logic        ok;
        logic [16:0] late;
        logic        last;
    } t_timer_event;

    typedef struct {
        logic [1:0]   cmd;
        logic [31:0]  interval;
        logic [31:0]  tid;
        bit           typed;
        t_timer_event want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // interval[31:0], timer_id[63:32]
    logic [1:0]  s_axis_tuser;   // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;   // result_id[31:0], ok[32], lateness[49:33]
    logic [1:0]  m_axis_tuser;   // kind[1:0]
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    timer_deadline_heap dut (.*);

    // timer model state
    logic [TW-1:0] sched_dl [CAP];
    logic [31:0]   sched_id [CAP];
    int            sched_cnt;
    logic [31:0]   sched_next_id;
    logic [TW-1:0] sched_now;
    logic [15:0]   sched_tol;

    t_timer_event pending_q[$];
    int  err_cnt;
    int  xfer_in_cnt;
    bit  quiet;
    bit  hold_armed;
    int  hold_left;
    int  idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    function automatic logic [TW-1:0] time_add(input logic [TW-1:0] a,
                                               input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TW] ? {TW{1'b1}} : s[TW-1:0];
    endfunction

    function automatic bit runs_first(input int a, input int b);
        if (sched_dl[a] != sched_dl[b]) return sched_dl[a] < sched_dl[b];
        return sched_id[a] < sched_id[b];
    endfunction

    function automatic void swap_slots(input int a, input int b);
        logic [TW-1:0] d;
        logic [31:0]   i;
        d = sched_dl[a]; i = sched_id[a];
        sched_dl[a] = sched_dl[b]; sched_id[a] = sched_id[b];
        sched_dl[b] = d; sched_id[b] = i;
    endfunction

    function automatic void bubble_up(input int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!runs_first(i, p)) break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void bubble_down(input int i);
        int l, m;
        forever begin
            l = 2 * i + 1;
            m = i;
            if (l < sched_cnt && runs_first(l, m)) m = l;
            if (l + 1 < sched_cnt && runs_first(l + 1, m)) m = l + 1;
            if (m == i) break;
            swap_slots(i, m);
            i = m;
        end
    endfunction

    function automatic void drop_slot(input int i);
        sched_cnt--;
        if (i != sched_cnt) begin
            sched_dl[i] = sched_dl[sched_cnt];
            sched_id[i] = sched_id[sched_cnt];
            bubble_up(i);
            bubble_down(i);
        end
    endfunction

    function automatic t_timer_event mk_event(input logic [1:0] kind, input logic [31:0] id,
                                              input logic ok, input logic [16:0] late,
                                              input logic last);
        t_timer_event e;
        e.kind = kind; e.id = id; e.ok = ok; e.late = late; e.last = last;
        return e;
    endfunction

    // Advance the timer model by one command and return its results.
    function automatic void schedule_step(input logic [1:0] cmd, input logic [31:0] interval,
                                          input logic [31:0] tid, ref t_timer_event res[$]);
        int i;
        bit found;
        longint late;
        logic [TW-1:0] limit;
        res = {};
        case (cmd)
            tdh_pkg::CMD_ADD: begin
                if (sched_cnt >= CAP) begin
                    res.insert(res.size(),
                               mk_event(tdh_pkg::KIND_ADD, 32'd0, 1'b0, 17'd0, 1'b1));
                end else begin
                    sched_dl[sched_cnt] = time_add(sched_now, {16'd0, interval});
                    sched_id[sched_cnt] = sched_next_id;
                    sched_cnt++;
                    bubble_up(sched_cnt - 1);
                    res.insert(res.size(),
                               mk_event(tdh_pkg::KIND_ADD, sched_next_id, 1'b1, 17'd0, 1'b1));
                    sched_next_id++;
                end
            end
            tdh_pkg::CMD_CANCEL: begin
                for (i = 0; i < sched_cnt; i++)
                    if (sched_id[i] == tid) break;
                found = (i < sched_cnt);
                if (found) drop_slot(i);
                res.insert(res.size(),
                           mk_event(tdh_pkg::KIND_CANCEL, tid, found, 17'd0, 1'b1));
            end
            tdh_pkg::CMD_TICK: begin
                sched_now = time_add(sched_now, 48'd1);
                limit = time_add(sched_now, {32'd0, sched_tol});
                while (res.size() < tdh_pkg::MAX_RESULTS && sched_cnt > 0 &&
                       sched_dl[0] <= limit) begin
                    late = longint'(sched_now) - longint'(sched_dl[0]);
                    if (late > 65535) late = 65535;
                    if (late < -65536) late = -65536;
                    res.insert(res.size(), mk_event(tdh_pkg::KIND_EXPIRY, sched_id[0], 1'b1,
                                                    late[16:0], 1'b0));
                    drop_slot(0);
                end
                if (res.size() > 0) res[res.size() - 1].last = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Offer one command; update the model on the transfer.
    task automatic send_cmd(input logic [1:0] cmd, input logic [31:0] interval,
                            input logic [31:0] tid, input bit typed,
                            input t_timer_event want);
        t_timer_event res[$];
        while (!quiet && $urandom_range(99) < 31) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {tid, interval};
        do @(posedge i_clk); while (!s_axis_tready);
        xfer_in_cnt <= xfer_in_cnt + 1;
        schedule_step(cmd, interval, tid, res);
        if (typed) pending_q.insert(pending_q.size(), want);
        else foreach (res[k]) pending_q.insert(pending_q.size(), res[k]);
    endtask

    // Hold the input idle until all results are back and the block settles.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [15:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sched_tol = v;
    endtask

    task automatic random_cmd();
        t_timer_event none;
        logic [1:0]  cmd;
        logic [31:0] iv, tid;
        int r;
        r = $urandom_range(99);
        cmd = (r < 35) ? tdh_pkg::CMD_ADD : (r < 55) ? tdh_pkg::CMD_CANCEL :
              (r < 95) ? tdh_pkg::CMD_TICK : CMD_UNUSED;
        r = $urandom_range(99);
        iv = (r < 70) ? $urandom_range(20) : (r < 90) ? $urandom_range(500) : $urandom;
        if (sched_cnt > 0 && $urandom_range(99) < 60)
            tid = sched_id[$urandom_range(sched_cnt - 1)];
        else if ($urandom_range(1))
            tid = $urandom;
        else
            tid = sched_next_id - $urandom_range(4);
        send_cmd(cmd, iv, tid, 1'b0, none);
    endtask

    t_stim_row directed [] = '{
        '{tdh_pkg::CMD_TICK,   32'd0,         32'd0,         1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}},
        '{tdh_pkg::CMD_ADD,    32'd0,         32'd0,         1'b1,
          '{tdh_pkg::KIND_ADD, 0, 1, 0, 1}},
        '{tdh_pkg::CMD_ADD,    32'hFFFF_FFFF, 32'd0,         1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}},
        '{tdh_pkg::CMD_ADD,    32'd5,         32'hFFFF_FFFF, 1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}},
        '{tdh_pkg::CMD_ADD,    32'd5,         32'd0,         1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}},
        '{tdh_pkg::CMD_ADD,    32'd5,         32'd0,         1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}},
        '{tdh_pkg::CMD_CANCEL, 32'd0,         32'd1,         1'b1,
          '{tdh_pkg::KIND_CANCEL, 1, 1, 0, 1}},
        '{tdh_pkg::CMD_CANCEL, 32'd0,         32'd1,         1'b1,
          '{tdh_pkg::KIND_CANCEL, 1, 0, 0, 1}},
        '{tdh_pkg::CMD_CANCEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{tdh_pkg::KIND_CANCEL, 32'hFFFF_FFFF, 0, 0, 1}},
        '{CMD_UNUSED,          32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}},
        '{tdh_pkg::CMD_TICK,   32'd0,         32'd0,         1'b1,
          '{tdh_pkg::KIND_EXPIRY, 0, 1, 1, 1}},
        '{tdh_pkg::CMD_TICK,   32'd0,         32'd0,         1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}},
        '{tdh_pkg::CMD_TICK,   32'd0,         32'd0,         1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}},
        '{tdh_pkg::CMD_TICK,   32'd0,         32'd0,         1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}},
        '{tdh_pkg::CMD_ADD,    32'd0,         32'd0,         1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}},
        '{tdh_pkg::CMD_ADD,    32'd1,         32'd0,         1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}},
        '{tdh_pkg::CMD_TICK,   32'd0,         32'd0,         1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}},
        '{tdh_pkg::CMD_TICK,   32'd0,         32'd0,         1'b0,
          '{tdh_pkg::KIND_ADD, 0, 0, 0, 0}}
    };

    // stimulus
    initial begin
        t_timer_event none;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tdh_pkg::CMD_TICK;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_rst_n       = 1'b0;
        err_cnt       = 0;
        xfer_in_cnt   = 0;
        quiet         = 1'b0;
        sched_cnt     = 0;
        sched_next_id = '0;
        sched_now     = '0;
        sched_tol     = 16'd1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n])
            send_cmd(directed[n].cmd, directed[n].interval, directed[n].tid,
                     directed[n].typed, directed[n].want);
        drain();

        // zero slack: fill past capacity, then every timer fires at or after its deadline
        write_tolerance(16'd0);
        repeat (CAP + 2) send_cmd(tdh_pkg::CMD_ADD, $urandom_range(3), 32'd0, 1'b0, none);
        send_cmd(tdh_pkg::CMD_CANCEL, 32'd0, sched_id[CAP - 1], 1'b0, none);
        repeat (6) send_cmd(tdh_pkg::CMD_TICK, 32'd0, 32'd0, 1'b0, none);
        drain();

        // widest slack: a full heap fires at one tick, earliest at -65535
        write_tolerance(16'hFFFF);
        send_cmd(tdh_pkg::CMD_ADD, 32'd65536, 32'd0, 1'b0, none);
        while (sched_cnt < CAP)
            send_cmd(tdh_pkg::CMD_ADD, $urandom_range(900), 32'd0, 1'b0, none);
        send_cmd(tdh_pkg::CMD_TICK, 32'd0, 32'd0, 1'b0, none);
        send_cmd(tdh_pkg::CMD_TICK, 32'd0, 32'd0, 1'b0, none);
        drain();

        write_tolerance(16'd1);
        for (int n = 0; n < 100; n++) begin
            quiet = (n >= 40 && n < 80);
            random_cmd();
        end
        // sender waits for every result to come back
        drain();

        write_tolerance(16'd3);
        for (int n = 0; n < 55; n++) random_cmd();
        drain();

        write_tolerance(16'($urandom));
        for (int n = 0; n < 55; n++) random_cmd();
        drain();

        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, plus one long hold-off mid-run
    always @(posedge i_clk) begin
        t_timer_event want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_armed    <= 1'b1;
            hold_left     <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_q.size() == 0) begin
                    report_mismatch("unexpected result", 64'(m_axis_tdata), 64'd0);
                end else begin
                    want = pending_q.pop_front();
                    if (m_axis_tuser != want.kind)
                        report_mismatch("kind", 64'(m_axis_tuser), 64'(want.kind));
                    if (m_axis_tdata[31:0] != want.id)
                        report_mismatch("result_id", 64'(m_axis_tdata[31:0]), 64'(want.id));
                    if (m_axis_tdata[32] != want.ok)
                        report_mismatch("ok", 64'(m_axis_tdata[32]), 64'(want.ok));
                    if (m_axis_tdata[49:33] != want.late)
                        report_mismatch("lateness", 64'(m_axis_tdata[49:33]),
                                        64'(want.late));
                    if (m_axis_tlast != want.last)
                        report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
                end
            end
            if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else if (hold_armed && xfer_in_cnt >= 150) begin
                hold_armed    <= 1'b0;
                hold_left     <= 400;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || $urandom_range(99) >= 31;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_MAX) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: sim.f
rtl/tdh_pkg.sv
rtl/tdh_ram.sv
rtl/tdh_cmp.sv
rtl/timer_deadline_heap.sv
bench/tb_top.sv
